>>> src/rfsb_pkg.sv
// Package with the types and constants shared by the blitter modules.
`default_nettype none

package rfsb_pkg;

    localparam logic [9:0] SCREEN_WIDTH  = 10'd320;
    localparam logic [8:0] SCREEN_HEIGHT = 9'd200;

    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_DEST_X      = 3'd1,
        REG_DEST_Y      = 3'd2,
        REG_RECT_WIDTH  = 3'd3,
        REG_RECT_HEIGHT = 3'd4,
        REG_FILL_COLOR  = 3'd5,
        REG_KEY_COLOR   = 3'd6
    } reg_idx_t;

    localparam logic MODE_COPY = 1'b0;
    localparam logic MODE_FILL = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [8:0] dest_x;
        logic [7:0] dest_y;
        logic [8:0] rect_width;
        logic [7:0] rect_height;
        logic [7:0] fill_color;
        logic [7:0] key_color;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic [8:0] column;
        logic [7:0] row;
        logic       done;
    } stage_t;

endpackage

`default_nettype wire

>>> src/rfsb_if.sv
// Handshake interfaces for the pixel input, result output and register write channels.
`default_nettype none

interface rfsb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

interface rfsb_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_color;
    logic        rect_done;

    modport source (output valid, output write_enable, output write_address,
                    output write_color, output rect_done, input ready);
    modport sink (input valid, input write_enable, input write_address,
                  input write_color, input rect_done, output ready);
endinterface

interface rfsb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rfsb_pkg::CFG_INDEX_W-1:0] index;
    logic [rfsb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/rfsb_cfg.sv
// Configuration register file with a restart pulse on every write to a listed register.
`default_nettype none

module rfsb_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rfsb_cfg_if.sink       cfg,
    output rfsb_pkg::cfg_t regs,
    output logic           restart
);

    rfsb_pkg::cfg_t regs_reg;
    rfsb_pkg::cfg_t regs_next;
    logic           write;

    assign cfg.ready = 1'b1;
    assign write = cfg.valid && cfg.ready;
    assign regs = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        restart = 1'b0;
        if (write)
        begin
            restart = 1'b1;
            case (cfg.index)
                rfsb_pkg::REG_MODE:        regs_next.mode = cfg.data[0];
                rfsb_pkg::REG_DEST_X:      regs_next.dest_x = cfg.data[8:0];
                rfsb_pkg::REG_DEST_Y:      regs_next.dest_y = cfg.data[7:0];
                rfsb_pkg::REG_RECT_WIDTH:  regs_next.rect_width = cfg.data[8:0];
                rfsb_pkg::REG_RECT_HEIGHT: regs_next.rect_height = cfg.data[7:0];
                rfsb_pkg::REG_FILL_COLOR:  regs_next.fill_color = cfg.data[7:0];
                rfsb_pkg::REG_KEY_COLOR:   regs_next.key_color = cfg.data[7:0];
                default:                   restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mode        <= rfsb_pkg::MODE_COPY;
            regs_reg.dest_x      <= 9'd0;
            regs_reg.dest_y      <= 8'd0;
            regs_reg.rect_width  <= 9'd320;
            regs_reg.rect_height <= 8'd200;
            regs_reg.fill_color  <= 8'd0;
            regs_reg.key_color   <= 8'd0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rfsb_walk.sv
// Rectangle walk counters and the input register that captures each accepted item.
`default_nettype none

module rfsb_walk (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rfsb_in_if.sink               pix_in,
    input  wire rfsb_pkg::cfg_t   regs,
    input  wire logic             restart,
    input  wire logic             take,
    output logic                  stage_valid,
    output rfsb_pkg::stage_t      stage
);

    logic             valid_reg;
    logic             valid_next;
    rfsb_pkg::stage_t stage_reg;
    logic [8:0]       column_reg;
    logic [8:0]       column_next;
    logic [7:0]       row_reg;
    logic [7:0]       row_next;
    logic [8:0]       width_eff;
    logic [7:0]       height_eff;
    logic             last_col;
    logic             last_row;
    logic             accept;

    assign pix_in.ready = !valid_reg || take;
    assign accept = pix_in.valid && pix_in.ready;
    assign stage_valid = valid_reg;
    assign stage = stage_reg;

    assign width_eff = (regs.rect_width == 9'd0) ? 9'd1 : regs.rect_width;
    assign height_eff = (regs.rect_height == 8'd0) ? 8'd1 : regs.rect_height;
    assign last_col = ({1'b0, column_reg} + 10'd1) >= {1'b0, width_eff};
    assign last_row = ({1'b0, row_reg} + 9'd1) >= {1'b0, height_eff};

    always_comb
    begin
        column_next = column_reg;
        row_next = row_reg;
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            if (last_col && last_row)
            begin
                column_next = 9'd0;
                row_next = 8'd0;
            end
            else if (last_col)
            begin
                column_next = 9'd0;
                row_next = row_reg + 8'd1;
            end
            else
            begin
                column_next = column_reg + 9'd1;
            end
        end
        if (restart)
        begin
            column_next = 9'd0;
            row_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            column_reg <= 9'd0;
            row_reg <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            column_reg <= column_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.pixel <= pix_in.pixel_color;
            stage_reg.column <= column_reg;
            stage_reg.row <= row_reg;
            stage_reg.done <= last_col && last_row;
        end
    end

endmodule

`default_nettype wire

>>> src/rfsb_pix.sv
// Pixel stage that clips, keys and addresses one item into the result register.
`default_nettype none

module rfsb_pix (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rfsb_pkg::cfg_t   regs,
    input  wire logic             stage_valid,
    input  wire rfsb_pkg::stage_t stage,
    output logic                  take,
    rfsb_out_if.source            res_out
);

    logic        valid_reg;
    logic        write_enable_reg;
    logic [15:0] write_address_reg;
    logic [7:0]  write_color_reg;
    logic        rect_done_reg;
    logic [9:0]  pos_x;
    logic [8:0]  pos_y;
    logic [18:0] linear;
    logic        on_screen;
    logic        opaque;
    logic [7:0]  color;

    assign take = stage_valid && (!valid_reg || res_out.ready);

    assign pos_x = {1'b0, regs.dest_x} + {1'b0, stage.column};
    assign pos_y = {1'b0, regs.dest_y} + {1'b0, stage.row};
    assign on_screen = (pos_x < rfsb_pkg::SCREEN_WIDTH) && (pos_y < rfsb_pkg::SCREEN_HEIGHT);
    assign linear = 19'(pos_y) * 19'(rfsb_pkg::SCREEN_WIDTH) + 19'(pos_x);
    assign color = (regs.mode == rfsb_pkg::MODE_FILL) ? regs.fill_color : stage.pixel;
    assign opaque = (regs.mode == rfsb_pkg::MODE_FILL) || (stage.pixel != regs.key_color);

    assign res_out.valid = valid_reg;
    assign res_out.write_enable = write_enable_reg;
    assign res_out.write_address = write_address_reg;
    assign res_out.write_color = write_color_reg;
    assign res_out.rect_done = rect_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            write_enable_reg <= on_screen && opaque;
            write_address_reg <= on_screen ? linear[15:0] : 16'd0;
            write_color_reg <= color;
            rect_done_reg <= stage.done;
        end
    end

endmodule

`default_nettype wire

>>> src/rect_fill_and_sprite_blitter.sv
// Top level of the rectangle fill and color-keyed sprite blitter.
// The blitter walks the programmed destination rectangle in row-major order and
// answers every input item with one result item: a write enable, a framebuffer
// byte address, a color and a flag on the rectangle's last pixel. It accepts one
// item per cycle while the result is not stalled; each item passes through the
// input register and then the result register. A stalled result holds the result
// register, and once the input register is full too, the input. The user must
// write registers through the configuration channel only while the block is
// idle; the block does not enforce this. Any write to a defined register
// restarts the walk at the first pixel.
`default_nettype none

module rect_fill_and_sprite_blitter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rfsb_cfg_if.sink   cfg,
    rfsb_in_if.sink    pix_in,
    rfsb_out_if.source res_out
);

    rfsb_pkg::cfg_t   regs;
    rfsb_pkg::stage_t stage;
    logic             restart;
    logic             stage_valid;
    logic             take;

    rfsb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .regs    (regs),
        .restart (restart)
    );

    rfsb_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_in      (pix_in),
        .regs        (regs),
        .restart     (restart),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    rfsb_pix u_pix (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .res_out     (res_out)
    );

endmodule

`default_nettype wire
